// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check, sampled on the rising clock, off while reset is high.
`define HRHT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hrht assertion failed");

// Same check, also active while reset is high.
`define HRHT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("hrht assertion failed");

`else

`define HRHT_ASSERT(label, clk, rst, prop)
`define HRHT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/hrht_pkg.sv =====
`timescale 1ns / 1ps

package hrht_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CNT_W     = 4;
   localparam logic [CNT_W-1:0] PROTO_LEN = 4'd8;
   localparam logic [CNT_W-1:0] PROTO_SAT = 4'd9;

   typedef enum logic [8:0] {
      STATE_METHOD = 9'b0_0000_0001,
      STATE_PATH   = 9'b0_0000_0010,
      STATE_PROTO  = 9'b0_0000_0100,
      STATE_HSTART = 9'b0_0000_1000,
      STATE_NAME   = 9'b0_0001_0000,
      STATE_SEP    = 9'b0_0010_0000,
      STATE_VALUE  = 9'b0_0100_0000,
      STATE_DONE   = 9'b0_1000_0000,
      STATE_ERR    = 9'b1_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      CL_BLANK = 3'd0,
      CL_CR    = 3'd1,
      CL_LF    = 3'd2,
      CL_COLON = 3'd3,
      CL_OTHER = 3'd4
   } class_type;

   typedef enum logic [2:0] {
      FLD_NONE   = 3'd0,
      FLD_METHOD = 3'd1,
      FLD_PATH   = 3'd2,
      FLD_PROTO  = 3'd3,
      FLD_NAME   = 3'd4,
      FLD_VALUE  = 3'd5
   } field_type;

   typedef enum logic [1:0] {
      STS_RUNNING  = 2'd0,
      STS_COMPLETE = 2'd1,
      STS_ERROR    = 2'd2
   } status_type;

   typedef struct packed {
      state_type        state;
      logic [CNT_W-1:0] proto_count;
      logic             proto_mismatch;
      logic             value_started;
   } ctx_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      field_type         role;
      field_type         closed;
      status_type        status;
   } result_type;

   localparam ctx_type CTX_RESTART = '{
      state:          STATE_METHOD,
      proto_count:    '0,
      proto_mismatch: 1'b0,
      value_started:  1'b0
   };

   function automatic class_type class_of(input logic [BYTE_W-1:0] b);
      class_type c;
      case (b) inside
         8'h20, 8'h09: c = CL_BLANK;
         8'h0D:        c = CL_CR;
         8'h0A:        c = CL_LF;
         8'h3A:        c = CL_COLON;
         default:      c = CL_OTHER;
      endcase
      return c;
   endfunction

   // expected protocol text, HTTP/1.1
   function automatic logic [BYTE_W-1:0] proto_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         3'd0:    ch = 8'h48;
         3'd1:    ch = 8'h54;
         3'd2:    ch = 8'h54;
         3'd3:    ch = 8'h50;
         3'd4:    ch = 8'h2F;
         3'd5:    ch = 8'h31;
         3'd6:    ch = 8'h2E;
         default: ch = 8'h31;
      endcase
      return ch;
   endfunction

   function automatic field_type field_of(input state_type st);
      field_type f;
      unique case (st)
         STATE_METHOD: f = FLD_METHOD;
         STATE_PATH:   f = FLD_PATH;
         STATE_PROTO:  f = FLD_PROTO;
         STATE_NAME:   f = FLD_NAME;
         STATE_VALUE:  f = FLD_VALUE;
         default:      f = FLD_NONE;
      endcase
      return f;
   endfunction

   function automatic state_type step_next(input state_type st, input class_type cl);
      state_type nx;
      nx = STATE_ERR;
      unique case (st)
         STATE_METHOD: begin
            unique case (cl)
               CL_BLANK: nx = STATE_PATH;
               CL_OTHER: nx = STATE_METHOD;
               default:  nx = STATE_ERR;
            endcase
         end
         STATE_PATH: begin
            unique case (cl) inside
               CL_BLANK:           nx = STATE_PROTO;
               CL_COLON, CL_OTHER: nx = STATE_PATH;
               default:            nx = STATE_ERR;
            endcase
         end
         STATE_PROTO: begin
            unique case (cl)
               CL_CR:    nx = STATE_HSTART;
               CL_LF:    nx = STATE_NAME;
               CL_OTHER: nx = STATE_PROTO;
               default:  nx = STATE_ERR;
            endcase
         end
         STATE_HSTART: begin
            nx = (cl == CL_LF) ? STATE_NAME : STATE_ERR;
         end
         STATE_NAME: begin
            unique case (cl)
               CL_BLANK: nx = STATE_SEP;
               CL_CR:    nx = STATE_DONE;
               CL_COLON: nx = STATE_VALUE;
               CL_OTHER: nx = STATE_NAME;
               default:  nx = STATE_ERR;
            endcase
         end
         STATE_SEP: begin
            unique case (cl)
               CL_BLANK: nx = STATE_SEP;
               CL_COLON: nx = STATE_VALUE;
               default:  nx = STATE_ERR;
            endcase
         end
         STATE_VALUE: begin
            unique case (cl)
               CL_CR:   nx = STATE_HSTART;
               CL_LF:   nx = STATE_NAME;
               default: nx = STATE_VALUE;
            endcase
         end
         default: nx = STATE_METHOD;
      endcase
      return nx;
   endfunction

endpackage

// ===== rtl/http_request_header_tokenizer_core.sv =====
// A byte accepted into the input register is stepped and its result registered in the result register,
// which drives rsp_valid. One byte per cycle, back to back, while rsp_stall is low. While the result is stalled
// one more byte is taken into the input register; req_stall then holds until the result drains.
// Reset (synchronous, active high): both stages empty, parser in the method state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module http_request_header_tokenizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_byte_role,
   output logic [2:0] rsp_closed_field,
   output logic [1:0] rsp_status
);
   import hrht_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type res_ff;
   result_type step_res;
   ctx_type    ctx_ff;
   ctx_type    step_ctx;
   logic       req_take;
   logic       move;

   hrht_step u_step (
      .cur     (ctx_ff),
      .in_byte (in_byte_ff),
      .nxt     (step_ctx),
      .res     (step_res)
   );

   // advance the held byte whenever the result register is free or drains
   assign move      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !move);
   assign out_valid_in = move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctx_ff       <= CTX_RESTART;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (move) begin
            ctx_ff <= step_ctx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      if (move) begin
         res_ff <= step_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = res_ff.out_byte;
   assign rsp_byte_role    = 3'(res_ff.role);
   assign rsp_closed_field = 3'(res_ff.closed);
   assign rsp_status       = 2'(res_ff.status);

   `HRHT_ASSERT(a_proto_count_sat, clock, reset, ctx_ff.proto_count <= PROTO_SAT)
   `HRHT_ASSERT(a_err_not_held, clock, reset, ctx_ff.state != STATE_ERR)
   `HRHT_ASSERT(a_error_restarts, clock, reset,
                (move && step_res.status != STS_RUNNING) |=> (ctx_ff.state == STATE_METHOD))
   `HRHT_ASSERT(a_name_lowered, clock, reset,
                (out_valid_ff && res_ff.role == FLD_NAME) |->
                !(res_ff.out_byte >= 8'h41 && res_ff.out_byte <= 8'h5A))
   `HRHT_ASSERT(a_no_overrun, clock, reset, req_take |-> (!in_valid_ff || move))

endmodule

// ===== rtl/hrht_step.sv =====
`timescale 1ns / 1ps

module hrht_step (
   input  hrht_pkg::ctx_type    cur,
   input  logic [7:0]           in_byte,
   output hrht_pkg::ctx_type    nxt,
   output hrht_pkg::result_type res
);
   import hrht_pkg::*;

   state_type st;
   state_type nx;
   class_type cl;
   logic      value_blank;
   logic      proto_bad;

   // anything that is not a live state behaves as the method state
   always_comb begin
      unique case (cur.state) inside
         STATE_METHOD, STATE_PATH, STATE_PROTO, STATE_HSTART,
         STATE_NAME, STATE_SEP, STATE_VALUE, STATE_DONE: st = cur.state;
         default:                                        st = STATE_METHOD;
      endcase
   end

   assign cl          = class_of(in_byte);
   assign value_blank = (in_byte == 8'h20) || (in_byte == 8'h09) ||
                        (in_byte == 8'h0B) || (in_byte == 8'h0C);
   assign proto_bad   = cur.proto_mismatch || (cur.proto_count != PROTO_LEN);

   always_comb begin
      nxt          = cur;
      nxt.state    = st;
      res.out_byte = in_byte;
      res.role     = FLD_NONE;
      res.closed   = FLD_NONE;
      res.status   = STS_RUNNING;
      nx           = step_next(st, cl);

      if (st == STATE_DONE) begin
         res.status = (cl == CL_LF) ? STS_COMPLETE : STS_ERROR;
         nxt        = CTX_RESTART;
      end else if (nx != st) begin
         res.closed = field_of(st);
         if (st == STATE_PROTO && proto_bad) begin
            nx = STATE_ERR;
         end
         if (nx == STATE_ERR) begin
            res.status = STS_ERROR;
            nxt        = CTX_RESTART;
         end else begin
            nxt.state = nx;
            if (nx == STATE_PROTO) begin
               nxt.proto_count    = '0;
               nxt.proto_mismatch = 1'b0;
            end else if (nx == STATE_VALUE) begin
               nxt.value_started = 1'b0;
            end
         end
      end else begin
         unique case (st)
            STATE_PROTO: begin
               if (cur.proto_count < PROTO_LEN) begin
                  if (in_byte != proto_char(cur.proto_count[2:0])) begin
                     nxt.proto_mismatch = 1'b1;
                  end
               end else begin
                  nxt.proto_mismatch = 1'b1;
               end
               if (cur.proto_count < PROTO_SAT) begin
                  nxt.proto_count = cur.proto_count + 4'd1;
               end
               res.role = FLD_PROTO;
            end
            STATE_NAME: begin
               if (in_byte >= 8'h41 && in_byte <= 8'h5A) begin
                  res.out_byte = in_byte + 8'd32;
               end
               res.role = FLD_NAME;
            end
            STATE_VALUE: begin
               // drop leading blanks of a value
               if (cur.value_started || !value_blank) begin
                  nxt.value_started = 1'b1;
                  res.role          = FLD_VALUE;
               end
            end
            STATE_METHOD: res.role = FLD_METHOD;
            STATE_PATH:   res.role = FLD_PATH;
            default:      res.role = FLD_NONE;
         endcase
      end
   end

endmodule
